// File: rtl/pis_pkg.sv
`timescale 1ns / 1ps
// Package for the pose inlier scoring unit: widths, register indexes,
// controller states and the datapath command and status structs. No dependencies.
package pis_pkg;
    localparam int MaxMatches = 4096;
    localparam int TallyW = 13;
    localparam int CfgW = 48;
    localparam int CfgIdxW = 3;
    localparam int PcW = 52;

    localparam logic [CfgIdxW-1:0] REG_ROT0 = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ROT1 = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ROT2 = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_TX = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TY = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_TZ = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE, ST_ROT, ST_ACC, ST_PC, ST_DOT, ST_NORM, ST_SQ, ST_CMP, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic [1:0] row;
        logic do_rot;
        logic do_acc;
        logic do_pc;
        logic do_dot;
        logic do_norm;
        logic do_sq;
        logic [1:0] sq_sel;
        logic [1:0] sq_phase;
        logic do_cmp;
    } cmd_t;

    typedef struct packed {
        logic inlier;
        logic last;
    } stat_t;
endpackage

// File: rtl/pis_datapath.sv
`timescale 1ns / 1ps
// Datapath of the pose inlier scoring unit: one shared set of registers that
// computes the camera point, dot product, squared terms and the threshold test. Uses pis_pkg.
module pis_datapath (
    input  logic                       aclk,
    input  pis_pkg::cmd_t              cmd,
    output pis_pkg::stat_t             stat,
    input  logic [47:0]                rot0,
    input  logic [47:0]                rot1,
    input  logic [47:0]                rot2,
    input  logic signed [31:0]         tx,
    input  logic signed [31:0]         ty,
    input  logic signed [31:0]         tz,
    input  logic signed [31:0]         lx,
    input  logic signed [31:0]         ly,
    input  logic signed [31:0]         lz,
    input  logic signed [15:0]         bx,
    input  logic signed [15:0]         by,
    input  logic signed [15:0]         bz,
    input  logic [16:0]                thr,
    input  logic                       last
);
    logic signed [31:0] lm_reg [3];
    logic signed [15:0] br_reg [3];
    logic [16:0] thr_reg;
    logic last_reg;
    logic signed [47:0] prod_reg [3];
    logic signed [49:0] acc_reg;
    logic signed [51:0] pc_reg [3];
    logic signed [67:0] dprod_reg [3];
    logic signed [69:0] dot_reg;
    logic [50:0] u_reg [3];
    logic [103:0] lhs_reg;
    logic [107:0] rhs_reg;
    logic inl_reg;
    logic [47:0] row_sel;
    logic signed [31:0] t_sel;
    logic [33:0] mag [3];
    logic [51:0] sq_op;
    logic [25:0] sq_a, sq_b;
    logic [51:0] sq_prod;
    logic [107:0] sq_add;

    always_comb begin
        unique case (cmd.row)
            2'd0: begin row_sel = rot0; t_sel = tx; end
            2'd1: begin row_sel = rot1; t_sel = ty; end
            default: begin row_sel = rot2; t_sel = tz; end
        endcase
        for (int i = 0; i < 3; i++) begin
            mag[i] = pc_reg[i][51] ? 34'(-pc_reg[i]) : 34'(pc_reg[i]);
        end
        unique case (cmd.sq_sel)
            2'd0: sq_op = {1'b0, u_reg[0]};
            2'd1: sq_op = {1'b0, u_reg[1]};
            2'd2: sq_op = {1'b0, u_reg[2]};
            default: sq_op = dot_reg[51:0];
        endcase
        unique case (cmd.sq_phase)
            2'd0: begin sq_a = sq_op[25:0]; sq_b = sq_op[25:0]; end
            2'd1: begin sq_a = sq_op[25:0]; sq_b = sq_op[51:26]; end
            default: begin sq_a = sq_op[51:26]; sq_b = sq_op[51:26]; end
        endcase
        sq_prod = 52'(sq_a) * 52'(sq_b);
        unique case (cmd.sq_phase)
            2'd0: sq_add = 108'(sq_prod);
            2'd1: sq_add = 108'(sq_prod) << 27;
            default: sq_add = 108'(sq_prod) << 52;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lm_reg[0] <= lx; lm_reg[1] <= ly; lm_reg[2] <= lz;
            br_reg[0] <= bx; br_reg[1] <= by; br_reg[2] <= bz;
            thr_reg <= thr;
            last_reg <= last;
            lhs_reg <= '0;
            rhs_reg <= '0;
        end
        if (cmd.do_rot) begin
            for (int j = 0; j < 3; j++) begin
                prod_reg[j] <= 48'($signed(row_sel[16*j +: 16]) * lm_reg[j]);
            end
        end
        if (cmd.do_acc) begin
            acc_reg <= 50'(prod_reg[0]) + 50'(prod_reg[1]) + 50'(prod_reg[2]);
        end
        if (cmd.do_pc) begin
            pc_reg[cmd.row] <= 52'(acc_reg >>> 14) + 52'(t_sel);
        end
        if (cmd.do_dot) begin
            for (int i = 0; i < 3; i++) begin
                dprod_reg[i] <= 68'($signed(pc_reg[i][35:0]) * br_reg[i]);
            end
        end
        if (cmd.do_norm) begin
            dot_reg <= 70'(dprod_reg[0]) + 70'(dprod_reg[1]) + 70'(dprod_reg[2]);
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= 51'(thr_reg) * 51'(mag[i]);
            end
        end
        if (cmd.do_sq) begin
            if (cmd.sq_sel == 2'd3) begin
                lhs_reg <= lhs_reg + sq_add[103:0];
            end else begin
                rhs_reg <= rhs_reg + sq_add;
            end
        end
        if (cmd.do_cmp) begin
            inl_reg <= !dot_reg[69] && (dot_reg != '0) && ({lhs_reg, 4'd0} > rhs_reg);
        end
    end

    assign stat.inlier = inl_reg;
    assign stat.last = last_reg;
endmodule

// File: rtl/pis_controller.sv
`timescale 1ns / 1ps
// Controller of the pose inlier scoring unit: sequences the datapath, owns the
// handshakes and the inlier tally. Uses pis_pkg.
module pis_controller (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_inlier_flag,
    output logic [pis_pkg::TallyW-1:0]  m_inliers_so_far,
    output logic                        m_final_result,
    output pis_pkg::cmd_t               cmd,
    input  pis_pkg::stat_t              stat
);
    pis_pkg::state_t state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] sel_reg, sel_next;
    logic [1:0] ph_reg, ph_next;
    logic [pis_pkg::TallyW-1:0] tally_reg, tally_next;
    logic mv_reg, mv_next;
    logic flag_reg, flag_next, fin_reg, fin_next;
    logic [pis_pkg::TallyW-1:0] cnt_reg, cnt_next;
    logic [pis_pkg::TallyW-1:0] inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pis_pkg::ST_IDLE;
            row_reg <= '0;
            sel_reg <= '0;
            ph_reg <= '0;
            tally_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg <= row_next;
            sel_reg <= sel_next;
            ph_reg <= ph_next;
            tally_reg <= tally_next;
            mv_reg <= mv_next;
        end
        flag_reg <= flag_next;
        fin_reg <= fin_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        state_next = state_reg;
        row_next = row_reg;
        sel_next = sel_reg;
        ph_next = ph_reg;
        tally_next = tally_reg;
        mv_next = mv_reg;
        flag_next = flag_reg;
        fin_next = fin_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        cmd.row = row_reg;
        cmd.sq_sel = sel_reg;
        cmd.sq_phase = ph_reg;
        s_ready = 1'b0;
        inc = (stat.inlier && tally_reg < pis_pkg::TallyW'(pis_pkg::MaxMatches))
            ? tally_reg + 1'b1 : tally_reg;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            pis_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    row_next = '0;
                    sel_next = '0;
                    ph_next = '0;
                    state_next = pis_pkg::ST_ROT;
                end
            end
            pis_pkg::ST_ROT: begin
                cmd.do_rot = 1'b1;
                state_next = pis_pkg::ST_ACC;
            end
            pis_pkg::ST_ACC: begin
                cmd.do_acc = 1'b1;
                state_next = pis_pkg::ST_PC;
            end
            pis_pkg::ST_PC: begin
                cmd.do_pc = 1'b1;
                if (row_reg == 2'd2) begin
                    state_next = pis_pkg::ST_DOT;
                end else begin
                    row_next = row_reg + 1'b1;
                    state_next = pis_pkg::ST_ROT;
                end
            end
            pis_pkg::ST_DOT: begin
                cmd.do_dot = 1'b1;
                state_next = pis_pkg::ST_NORM;
            end
            pis_pkg::ST_NORM: begin
                cmd.do_norm = 1'b1;
                state_next = pis_pkg::ST_SQ;
            end
            pis_pkg::ST_SQ: begin
                cmd.do_sq = 1'b1;
                if (ph_reg == 2'd2) begin
                    ph_next = '0;
                    if (sel_reg == 2'd3) begin
                        state_next = pis_pkg::ST_CMP;
                    end else begin
                        sel_next = sel_reg + 1'b1;
                    end
                end else begin
                    ph_next = ph_reg + 1'b1;
                end
            end
            pis_pkg::ST_CMP: begin
                cmd.do_cmp = 1'b1;
                state_next = pis_pkg::ST_OUT;
            end
            pis_pkg::ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next = 1'b1;
                    flag_next = stat.inlier;
                    cnt_next = inc;
                    fin_next = stat.last;
                    tally_next = stat.last ? '0 : inc;
                    state_next = pis_pkg::ST_IDLE;
                end
            end
            default: state_next = pis_pkg::ST_IDLE;
        endcase
    end

    assign m_valid = mv_reg;
    assign m_inlier_flag = flag_reg;
    assign m_inliers_so_far = cnt_reg;
    assign m_final_result = fin_reg;

    a_tally_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tally_reg <= pis_pkg::TallyW'(pis_pkg::MaxMatches))
        else $error("tally above limit");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == pis_pkg::ST_IDLE)
        else $error("ready outside idle");
    a_last_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pis_pkg::ST_OUT && state_next == pis_pkg::ST_IDLE && stat.last)
        |=> tally_reg == '0)
        else $error("tally not cleared");
endmodule

// File: rtl/pose_inlier_scoring_unit.sv
`timescale 1ns / 1ps
// Pose inlier scoring unit: top level joining pis_controller and pis_datapath.
// Depends on pis_pkg.
// For each match, the camera point is built one rotation row at a time through a
// shared row multiplier, then the dot product follows, and the squared terms of
// both sides of the threshold test are accumulated through one shared squaring
// unit in three steps per term. The next match can be accepted in the cycle after
// the result is registered; no new match is taken while one is in progress. A
// finished result is held in an output register while the next match is
// processed. The inlier count saturates at 4096 and clears after the match
// marked last.
module pose_inlier_scoring_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [47:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_landmark_x,
    input  logic signed [31:0]  s_landmark_y,
    input  logic signed [31:0]  s_landmark_z,
    input  logic signed [15:0]  s_bearing_x,
    input  logic signed [15:0]  s_bearing_y,
    input  logic signed [15:0]  s_bearing_z,
    input  logic [16:0]         s_cos_threshold,
    input  logic                s_last_match,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_inlier_flag,
    output logic [12:0]         m_inliers_so_far,
    output logic                m_final_result
);
    logic [47:0] rot0_reg, rot1_reg, rot2_reg;
    logic signed [31:0] tx_reg, ty_reg, tz_reg;
    pis_pkg::cmd_t cmd;
    pis_pkg::stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot0_reg <= 48'd16384;
            rot1_reg <= 48'd1073741824;
            rot2_reg <= 48'd70368744177664;
            tx_reg <= '0;
            ty_reg <= '0;
            tz_reg <= '0;
        end else if (cfg_we) begin
            priority case (cfg_index)
                pis_pkg::REG_ROT0: rot0_reg <= cfg_data;
                pis_pkg::REG_ROT1: rot1_reg <= cfg_data;
                pis_pkg::REG_ROT2: rot2_reg <= cfg_data;
                pis_pkg::REG_TX: tx_reg <= cfg_data[31:0];
                pis_pkg::REG_TY: ty_reg <= cfg_data[31:0];
                pis_pkg::REG_TZ: tz_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    pis_controller u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .m_inlier_flag(m_inlier_flag),
        .m_inliers_so_far(m_inliers_so_far), .m_final_result(m_final_result),
        .cmd(cmd), .stat(stat)
    );

    pis_datapath u_dp (
        .aclk(aclk), .cmd(cmd), .stat(stat),
        .rot0(rot0_reg), .rot1(rot1_reg), .rot2(rot2_reg),
        .tx(tx_reg), .ty(ty_reg), .tz(tz_reg),
        .lx(s_landmark_x), .ly(s_landmark_y), .lz(s_landmark_z),
        .bx(s_bearing_x), .by(s_bearing_y), .bz(s_bearing_z),
        .thr(s_cos_threshold), .last(s_last_match)
    );
endmodule

// File: test/tb_pose_inlier_scoring_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for pose_inlier_scoring_unit: matches are scored by an
// internal fixed-point predictor and every result is compared in order.
// Depends on pis_pkg and the unit's RTL.
module tb_pose_inlier_scoring_unit;
    localparam logic [pis_pkg::CfgIdxW-1:0] REG_SPARE0 = 3'd6;
    localparam logic [pis_pkg::CfgIdxW-1:0] REG_SPARE1 = 3'd7;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 24;

    typedef struct {
        logic signed [31:0] lm [3];
        logic signed [15:0] br [3];
        logic [16:0]        thr;
        logic               last;
    } match_t;

    typedef struct packed {
        logic        inlier;
        logic [12:0] count;
        logic        final_flag;
    } score_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_we;
    logic [2:0] cfg_index;
    logic [47:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic signed [31:0] s_landmark_x, s_landmark_y, s_landmark_z;
    logic signed [15:0] s_bearing_x, s_bearing_y, s_bearing_z;
    logic [16:0] s_cos_threshold;
    logic s_last_match;
    logic m_valid;
    logic m_ready;
    logic m_inlier_flag;
    logic [12:0] m_inliers_so_far;
    logic m_final_result;

    logic [47:0] rot_mirror [3];
    logic signed [31:0] trans_mirror [3];
    int unsigned tally_mirror;
    score_t expected_scores [$];
    int err_cnt = 0;
    int hold_cycles = 0;
    bit quiet = 1'b0;
    int idle_cnt = 0;

    pose_inlier_scoring_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_landmark_x(s_landmark_x), .s_landmark_y(s_landmark_y),
        .s_landmark_z(s_landmark_z),
        .s_bearing_x(s_bearing_x), .s_bearing_y(s_bearing_y), .s_bearing_z(s_bearing_z),
        .s_cos_threshold(s_cos_threshold), .s_last_match(s_last_match),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_inlier_flag(m_inlier_flag), .m_inliers_so_far(m_inliers_so_far),
        .m_final_result(m_final_result)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic angular_inlier(match_t m);
        logic signed [127:0] acc, pc, dot, norm2, lhs, rhs, thr;
        dot = 0;
        norm2 = 0;
        thr = $signed({111'd0, m.thr});
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                acc = acc + $signed(rot_mirror[i][16*j +: 16]) * m.lm[j];
            end
            pc = (acc >>> 14) + trans_mirror[i];
            dot = dot + pc * m.br[i];
            norm2 = norm2 + pc * pc;
        end
        if (dot <= 0) return 1'b0;
        lhs = 16 * dot * dot;
        rhs = norm2 * thr * thr;
        return lhs > rhs;
    endfunction

    task automatic report(string what, int unsigned got, int unsigned want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        if (idx <= pis_pkg::REG_ROT2) begin
            rot_mirror[idx[1:0]] = data;
        end else if (idx <= pis_pkg::REG_TZ) begin
            trans_mirror[2'(idx - pis_pkg::REG_TX)] = data[31:0];
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_pose(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
                            logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
        wait_drained();
        write_reg(pis_pkg::REG_ROT0, r0);
        write_reg(pis_pkg::REG_ROT1, r1);
        write_reg(pis_pkg::REG_ROT2, r2);
        write_reg(pis_pkg::REG_TX, {16'd0, tx});
        write_reg(pis_pkg::REG_TY, {16'd0, ty});
        write_reg(pis_pkg::REG_TZ, {16'd0, tz});
    endtask

    task automatic send_match(match_t m);
        int gap;
        score_t exp_s;
        s_valid <= 1'b1;
        s_landmark_x <= m.lm[0];
        s_landmark_y <= m.lm[1];
        s_landmark_z <= m.lm[2];
        s_bearing_x <= m.br[0];
        s_bearing_y <= m.br[1];
        s_bearing_z <= m.br[2];
        s_cos_threshold <= m.thr;
        s_last_match <= m.last;
        do @(posedge aclk); while (!s_ready);
        exp_s.inlier = angular_inlier(m);
        if (exp_s.inlier && tally_mirror < pis_pkg::MaxMatches) tally_mirror++;
        exp_s.count = tally_mirror[12:0];
        exp_s.final_flag = m.last;
        if (m.last) tally_mirror = 0;
        expected_scores.push_back(exp_s);
        gap = 0;
        if (!quiet) begin
            case ($urandom_range(9))
                6, 7, 8: gap = $urandom_range(1, 3);
                9: gap = ($urandom_range(4) == 0) ? $urandom_range(10, 30) : 4;
                default: gap = 0;
            endcase
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic match_t make_match(int lx, int ly, int lz, int bx, int by, int bz,
                                          int thr, bit last);
        match_t m;
        m.lm[0] = lx; m.lm[1] = ly; m.lm[2] = lz;
        m.br[0] = 16'(bx); m.br[1] = 16'(by); m.br[2] = 16'(bz);
        m.thr = 17'(thr);
        m.last = last;
        return m;
    endfunction

    function automatic match_t random_match(bit aligned);
        match_t m;
        int scale;
        for (int i = 0; i < 3; i++) begin
            m.br[i] = 16'(($urandom_range(7) == 0) ? $urandom()
                                                   : $urandom_range(32768) - 16384);
            scale = $urandom_range(1, 1 << $urandom_range(16));
            m.lm[i] = aligned ? m.br[i] * scale : $urandom() >>> $urandom_range(31);
        end
        m.thr = 17'(($urandom_range(5) == 0) ? $urandom() : $urandom_range(65000));
        m.last = ($urandom_range(15) == 0);
        return m;
    endfunction

    function automatic logic [47:0] random_row();
        return 48'({$urandom(), $urandom()});
    endfunction

    task automatic test_directed();
        set_pose(48'd16384, 48'd1073741824, 48'd70368744177664, 0, 0, 0);
        send_match(make_match(0, 0, 4096, 0, 0, 16384, 0, 0));
        send_match(make_match(0, 0, 4096, 0, 0, 16384, 60000, 0));
        send_match(make_match(0, 0, 0, 0, 0, 16384, 0, 0));
        send_match(make_match(0, 0, 4096, 0, 0, 16384, 65536, 0));
        send_match(make_match(0, 0, 4096, 0, 0, 16384, 17'h1FFFF, 0));
        send_match(make_match(0, 0, 4096, 0, 0, -16384, 0, 0));
        send_match(make_match(4096, 4096, 4096, 32767, 32767, 32767, 30000, 0));
        send_match(make_match(4096, 4096, 4096, -32768, -32768, -32768, 30000, 0));
        send_match(make_match(-2147483648, -2147483648, -2147483648,
                              -16384, -16384, -16384, 1000, 0));
        send_match(make_match(2147483647, 2147483647, 2147483647,
                              16384, 16384, 16384, 65535, 0));
        send_match(make_match(0, 0, 4096, 0, 0, 16384, 0, 1));
        send_match(make_match(1, -1, 1, 1, 1, 1, 0, 1));
    endtask

    task automatic test_config_extremes();
        set_pose({3{16'h8000}}, {3{16'h7FFF}}, {16'h7FFF, 16'h8000, 16'h0000},
                 32'h7FFFFFFF, 32'h80000000, 32'h00000001);
        write_reg(REG_SPARE0, random_row());
        write_reg(REG_SPARE1, random_row());
        send_match(make_match(2147483647, -2147483648, 2147483647, 16384, -16384, 16384, 0, 0));
        send_match(make_match(-2147483648, -2147483648, -2147483648, -16384, 16384, 0, 100, 0));
        send_match(make_match(0, 0, 0, 16384, -16384, 16384, 0, 1));
        set_pose(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd0, 32'h80000000, 32'h7FFFFFFF, 0);
        send_match(make_match(2147483647, 2147483647, 2147483647, 16384, -16384, 0, 500, 0));
        send_match(make_match(0, 0, 0, -16384, 16384, 0, 0, 1));
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 400;
        for (int n = 0; n < 40; n++) send_match(random_match(1'b1));
        wait_drained();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: set_pose(48'd16384, 48'd1073741824, 48'd70368744177664,
                            $urandom_range(255) - 128, $urandom_range(255) - 128,
                            $urandom_range(255) - 128);
                1: set_pose(random_row(), random_row(), random_row(),
                            $urandom(), $urandom(), $urandom());
                2: set_pose(48'd16384, 48'd1073741824, 48'd70368744177664, 0, 0, 0);
                default: set_pose(random_row(), random_row(), random_row(), 0, 0, 0);
            endcase
            quiet = (phase == 5);
            for (int n = 0; n < 100; n++) begin
                send_match(random_match(phase % 4 != 1 && $urandom_range(4) != 0));
            end
            quiet = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        score_t got;
        if (m_valid && m_ready) begin
            got = '{m_inlier_flag, m_inliers_so_far, m_final_result};
            if (expected_scores.size() == 0) begin
                report("unexpected result transfer", 1, 0);
            end else begin
                score_t want;
                want = expected_scores.pop_front();
                if (got.inlier !== want.inlier) report("inlier_flag", got.inlier, want.inlier);
                if (got.count !== want.count) report("inliers_so_far", got.count, want.count);
                if (got.final_flag !== want.final_flag) begin
                    report("final_result", got.final_flag, want.final_flag);
                end
            end
        end
    end

    int stall_left = 0;
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(5) == 0) begin
            stall_left <= ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_landmark_x <= '0;
        s_landmark_y <= '0;
        s_landmark_z <= '0;
        s_bearing_x <= '0;
        s_bearing_y <= '0;
        s_bearing_z <= '0;
        s_cos_threshold <= '0;
        s_last_match <= 1'b0;
        m_ready <= 1'b0;
        rot_mirror[0] = 48'd16384;
        rot_mirror[1] = 48'd1073741824;
        rot_mirror[2] = 48'd70368744177664;
        for (int i = 0; i < 3; i++) trans_mirror[i] = 0;
        tally_mirror = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random();
        wait_drained();
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
